// ===== rtl/hmcp_pkg.sv =====
// Shared types, codes and helpers of the monitor command-line parser.
package hmcp_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [31:0] RUN_LIMIT  = 32'h0001_0000;
    localparam logic [31:0] ADDR_CLAMP = 32'h0FFF_FFFF;
    localparam logic [7:0]  CASE_BIT   = 8'h20;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_UC_R  = 8'h52;
    localparam logic [7:0] CH_LC_R  = 8'h72;

    typedef enum logic [2:0] {
        OP_READ    = 3'd0,
        OP_WRITE   = 3'd1,
        OP_RUN     = 3'd2,
        OP_SYNTAX  = 3'd3,
        OP_RUN_ERR = 3'd4,
        OP_DONE    = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        MODE_EXAMINE = 3'b001,
        MODE_STORE   = 3'b010,
        MODE_RANGE   = 3'b100
    } mode_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] addr_from;
        logic [31:0] addr_to;
        logic [7:0]  data_byte;
        logic        last;
    } res_t;

    typedef struct packed {
        logic two;
        res_t first;
        res_t second;
    } rec_t;

    function automatic logic [31:0] clamp_addr(input logic [31:0] a);
        return (a > ADDR_CLAMP) ? ADDR_CLAMP : a;
    endfunction

    function automatic res_t mk_res(input op_t op, input logic [31:0] from,
                                    input logic [31:0] to, input logic [7:0] data);
        res_t r;
        r.op        = op;
        r.addr_from = from;
        r.addr_to   = to;
        r.data_byte = data;
        r.last      = 1'b0;
        return r;
    endfunction

endpackage

// ===== rtl/hmcp_intf.sv =====
// Handshake channels: one carries characters in, one carries command words out.
interface hmcp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    modport source (output valid, output char_code, input ready);
    modport sink (input valid, input char_code, output ready);
endinterface

interface hmcp_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [31:0] addr_from;
    logic [31:0] addr_to;
    logic [7:0]  data_byte;
    logic        last;
    modport source (output valid, output op, output addr_from, output addr_to,
                    output data_byte, output last, input ready);
    modport sink (input valid, input op, input addr_from, input addr_to,
                  input data_byte, input last, output ready);
endinterface

// ===== rtl/hmcp_front.sv =====
// Front end: takes characters, keeps the line state and builds command records.
module hmcp_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     char_code,
    input  logic           q_full,
    output logic           push,
    output hmcp_pkg::rec_t rec
);

    hmcp_pkg::mode_t mode_reg, mode_next;
    logic [31:0]     acc_reg, acc_next;
    logic            open_reg, open_next;
    logic [31:0]     cur_reg, cur_next;
    logic            pend_reg, pend_next;
    logic            dead_reg, dead_next;

    logic            accept;
    logic [7:0]      lc;
    logic            is_dec;
    logic            is_hex;
    logic [3:0]      digit;
    logic [31:0]     cur_a;
    logic            pend_a;
    logic            v0, v1, v2;
    hmcp_pkg::res_t  r0, r1, r2;
    hmcp_pkg::res_t  first_w, second_w;
    logic            two;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign lc     = char_code | hmcp_pkg::CASE_BIT;
    assign is_dec = (char_code >= hmcp_pkg::CH_ZERO) && (char_code <= hmcp_pkg::CH_NINE);
    assign is_hex = is_dec || ((lc >= hmcp_pkg::CH_LC_A) && (lc <= hmcp_pkg::CH_LC_F));
    assign digit  = is_dec ? char_code[3:0] : (lc[3:0] + 4'd9);

    always_comb
    begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        open_next = open_reg;
        cur_next  = cur_reg;
        pend_next = pend_reg;
        dead_next = dead_reg;
        cur_a     = cur_reg;
        pend_a    = pend_reg;
        v0 = 1'b0;
        v1 = 1'b0;
        v2 = 1'b0;
        r0 = hmcp_pkg::mk_res(hmcp_pkg::OP_DONE, 32'd0, 32'd0, 8'd0);
        r1 = r0;
        r2 = r0;

        if (dead_reg)
        begin
            if (char_code == hmcp_pkg::CH_NUL)
            begin
                v2        = 1'b1;
                mode_next = hmcp_pkg::MODE_EXAMINE;
                acc_next  = 32'd0;
                open_next = 1'b0;
                pend_next = 1'b0;
                dead_next = 1'b0;
            end
        end
        else if (is_hex)
        begin
            if (pend_reg)
            begin
                v1 = 1'b1;
                r1 = hmcp_pkg::mk_res(hmcp_pkg::OP_READ, cur_reg,
                                      hmcp_pkg::clamp_addr(cur_reg), 8'd0);
            end
            pend_next = 1'b0;
            acc_next  = {acc_reg[27:0], digit};
            open_next = 1'b1;
        end
        else
        begin
            // close any open number
            if (open_reg)
            begin
                open_next = 1'b0;
                acc_next  = 32'd0;
                unique case (mode_reg)
                    hmcp_pkg::MODE_STORE:
                    begin
                        v0    = 1'b1;
                        r0    = hmcp_pkg::mk_res(hmcp_pkg::OP_WRITE, cur_reg, 32'd0,
                                                 acc_reg[7:0]);
                        cur_a = cur_reg + 32'd1;
                    end
                    hmcp_pkg::MODE_RANGE:
                    begin
                        v0        = 1'b1;
                        r0        = hmcp_pkg::mk_res(hmcp_pkg::OP_READ, cur_reg,
                                                     hmcp_pkg::clamp_addr(acc_reg), 8'd0);
                        cur_a     = acc_reg + 32'd1;
                        mode_next = hmcp_pkg::MODE_EXAMINE;
                    end
                    default:
                    begin
                        cur_a  = acc_reg;
                        pend_a = 1'b1;
                    end
                endcase
            end
            cur_next  = cur_a;
            pend_next = pend_a;

            if (char_code != hmcp_pkg::CH_SPACE)
            begin
                // settle a waiting examine
                pend_next = 1'b0;
                if (pend_a && (char_code != hmcp_pkg::CH_DOT))
                begin
                    v1 = 1'b1;
                    r1 = hmcp_pkg::mk_res(hmcp_pkg::OP_READ, cur_a,
                                          hmcp_pkg::clamp_addr(cur_a), 8'd0);
                end

                if (char_code == hmcp_pkg::CH_NUL)
                begin
                    v2        = 1'b1;
                    mode_next = hmcp_pkg::MODE_EXAMINE;
                    acc_next  = 32'd0;
                    open_next = 1'b0;
                    dead_next = 1'b0;
                end
                else if (char_code == hmcp_pkg::CH_COLON)
                begin
                    mode_next = hmcp_pkg::MODE_STORE;
                end
                else if (char_code == hmcp_pkg::CH_DOT)
                begin
                    mode_next = hmcp_pkg::MODE_RANGE;
                end
                else if ((char_code == hmcp_pkg::CH_UC_R) || (char_code == hmcp_pkg::CH_LC_R))
                begin
                    v2        = 1'b1;
                    r2        = hmcp_pkg::mk_res((cur_a < hmcp_pkg::RUN_LIMIT) ?
                                                 hmcp_pkg::OP_RUN : hmcp_pkg::OP_RUN_ERR,
                                                 cur_a, 32'd0, 8'd0);
                    dead_next = 1'b1;
                end
                else
                begin
                    v2        = 1'b1;
                    r2        = hmcp_pkg::mk_res(hmcp_pkg::OP_SYNTAX, 32'd0, 32'd0, 8'd0);
                    dead_next = 1'b1;
                end
            end
        end
    end

    // pack the first two words, drop any third
    always_comb
    begin
        if (v0)
        begin
            first_w  = r0;
            second_w = v1 ? r1 : r2;
            two      = v1 || v2;
        end
        else if (v1)
        begin
            first_w  = r1;
            second_w = r2;
            two      = v2;
        end
        else
        begin
            first_w  = r2;
            second_w = r2;
            two      = 1'b0;
        end
        first_w.last  = !two;
        second_w.last = 1'b1;
        rec.two       = two;
        rec.first     = first_w;
        rec.second    = second_w;
    end

    assign push = accept && (v0 || v1 || v2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= hmcp_pkg::MODE_EXAMINE;
            acc_reg  <= 32'd0;
            open_reg <= 1'b0;
            cur_reg  <= 32'd0;
            pend_reg <= 1'b0;
            dead_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            open_reg <= open_next;
            cur_reg  <= cur_next;
            pend_reg <= pend_next;
            dead_reg <= dead_next;
        end
    end

endmodule

// ===== rtl/hmcp_queue.sv =====
// Short record queue between the front end and the back end.
module hmcp_queue
#(
    parameter int DEPTH = hmcp_pkg::QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  hmcp_pkg::rec_t push_rec,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output hmcp_pkg::rec_t q_rec
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    hmcp_pkg::rec_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_pop;

    assign full    = (cnt_reg == CNT_FULL);
    assign q_valid = (cnt_reg != '0);
    assign q_rec   = mem_reg[rd_reg];
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == PTR_LAST) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == PTR_LAST) ? '0 : rd_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== rtl/hmcp_back.sv =====
// Back end: holds one record and issues its words one at a time.
module hmcp_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  hmcp_pkg::rec_t q_rec,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output hmcp_pkg::res_t out_word
);

    logic           hold_valid_reg;
    hmcp_pkg::rec_t hold_rec_reg;
    logic           second_reg;
    logic           taken;
    logic           done;
    logic           load;

    assign out_valid = hold_valid_reg;
    assign out_word  = second_reg ? hold_rec_reg.second : hold_rec_reg.first;
    assign taken     = hold_valid_reg && out_ready;
    assign done      = taken && (second_reg || !hold_rec_reg.two);
    assign load      = !hold_valid_reg || done;
    assign pop       = load && q_valid;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            hold_rec_reg <= q_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            second_reg     <= 1'b0;
        end
        else if (load)
        begin
            hold_valid_reg <= q_valid;
            second_reg     <= 1'b0;
        end
        else if (taken)
        begin
            second_reg <= 1'b1;
        end
    end

endmodule

// ===== rtl/hex_monitor_command_parser.sv =====
// Top level of the monitor command-line parser.
//
//  channel   dir  modport  word
//  char_in   in   sink     char_code (8)
//  res_out   out  source   op (3), addr_from (32), addr_to (32), data_byte (8), last (1)
//
//  When a character is taken, the front end updates the line state and
//  queues a record of up to two command words in the same cycle.
//  The back end issues one word per cycle while res_out.ready is high.
//  char_in.ready drops only while the record queue (QUEUE_DEPTH records) is full.
//  Reset clears the line state, the current address and the queue.
module hex_monitor_command_parser
#(
    parameter int QUEUE_DEPTH = hmcp_pkg::QUEUE_DEPTH
)
(
    input logic         clk,
    input logic         rst_n,
    hmcp_char_if.sink   char_in,
    hmcp_res_if.source  res_out
);

    logic           q_full;
    logic           push;
    hmcp_pkg::rec_t push_rec;
    logic           pop;
    logic           q_valid;
    hmcp_pkg::rec_t q_rec;
    hmcp_pkg::res_t out_word;

    hmcp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (char_in.valid),
        .in_ready  (char_in.ready),
        .char_code (char_in.char_code),
        .q_full    (q_full),
        .push      (push),
        .rec       (push_rec)
    );

    hmcp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_rec    (q_rec)
    );

    hmcp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_rec     (q_rec),
        .pop       (pop),
        .out_valid (res_out.valid),
        .out_ready (res_out.ready),
        .out_word  (out_word)
    );

    assign res_out.op        = out_word.op;
    assign res_out.addr_from = out_word.addr_from;
    assign res_out.addr_to   = out_word.addr_to;
    assign res_out.data_byte = out_word.data_byte;
    assign res_out.last      = out_word.last;

endmodule

// ===== rtl/hmcp_checker.sv =====
// Port-level checks of the parser, bound to the top level.
module hmcp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  op,
    input logic [31:0] addr_from,
    input logic [31:0] addr_to,
    input logic [7:0]  data_byte,
    input logic        last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(op) && $stable(addr_from)
            && $stable(addr_to) && $stable(data_byte) && $stable(last))
        else $error("stalled output word changed");

    a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid)
        else $error("second word of a character not presented at once");

    a_first_is_access: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> (op == hmcp_pkg::OP_READ) || (op == hmcp_pkg::OP_WRITE))
        else $error("non-final word is not a read or write");

    a_run_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (op == hmcp_pkg::OP_RUN) |-> (addr_from[31:16] == 16'd0) && last)
        else $error("run issued at an address of 16 bits or more");

endmodule

bind hex_monitor_command_parser hmcp_checker u_hmcp_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (res_out.valid),
    .out_ready (res_out.ready),
    .op        (res_out.op),
    .addr_from (res_out.addr_from),
    .addr_to   (res_out.addr_to),
    .data_byte (res_out.data_byte),
    .last      (res_out.last)
);

// ===== dv/tb_hex_monitor_command_parser.sv =====
// Testbench for hex_monitor_command_parser: random command lines against a line-state predictor.
module tb_hex_monitor_command_parser;

    localparam int ITEM_COUNT   = 1400;
    localparam int CALM_ITEMS   = 200;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;

    class command_tracker;
        hmcp_pkg::res_t  due_words[$];
        hmcp_pkg::res_t  batch[$];
        int              errors;
        hmcp_pkg::mode_t mode;
        logic [31:0]     acc;
        bit              digits_seen;
        logic [31:0]     cur_addr;
        bit              examine_due;
        bit              line_ignored;

        function new();
            clear_line();
            cur_addr = '0;
            errors   = 0;
        endfunction

        function void clear_line();
            mode         = hmcp_pkg::MODE_EXAMINE;
            acc          = '0;
            digits_seen  = 1'b0;
            examine_due  = 1'b0;
            line_ignored = 1'b0;
        endfunction

        function logic [31:0] ceiling_addr(input logic [31:0] a);
            return (a > hmcp_pkg::ADDR_CLAMP) ? hmcp_pkg::ADDR_CLAMP : a;
        endfunction

        function void add_word(input hmcp_pkg::op_t op, input logic [31:0] from,
                               input logic [31:0] to, input logic [7:0] data);
            hmcp_pkg::res_t w;
            if (batch.size() >= 2)
            begin
                return;
            end
            w.op        = op;
            w.addr_from = from;
            w.addr_to   = to;
            w.data_byte = data;
            w.last      = 1'b0;
            batch.push_back(w);
        endfunction

        function void close_number();
            logic [31:0] v;
            if (!digits_seen)
            begin
                return;
            end
            v           = acc;
            digits_seen = 1'b0;
            acc         = '0;
            case (mode)
                hmcp_pkg::MODE_STORE:
                begin
                    add_word(hmcp_pkg::OP_WRITE, cur_addr, '0, v[7:0]);
                    cur_addr = cur_addr + 32'd1;
                end
                hmcp_pkg::MODE_RANGE:
                begin
                    add_word(hmcp_pkg::OP_READ, cur_addr, ceiling_addr(v), '0);
                    cur_addr = v + 32'd1;
                    mode     = hmcp_pkg::MODE_EXAMINE;
                end
                default:
                begin
                    cur_addr    = v;
                    examine_due = 1'b1;
                end
            endcase
        endfunction

        function void settle_examine(input logic [7:0] c);
            if (!examine_due)
            begin
                return;
            end
            examine_due = 1'b0;
            if (c != hmcp_pkg::CH_DOT)
            begin
                add_word(hmcp_pkg::OP_READ, cur_addr, ceiling_addr(cur_addr), '0);
            end
        endfunction

        function void take_char(input logic [7:0] c);
            logic [7:0] lc;
            logic [7:0] digit;
            lc = c | hmcp_pkg::CASE_BIT;
            batch.delete();
            if (line_ignored)
            begin
                if (c == hmcp_pkg::CH_NUL)
                begin
                    add_word(hmcp_pkg::OP_DONE, '0, '0, '0);
                    clear_line();
                end
            end
            else if ((c >= hmcp_pkg::CH_ZERO && c <= hmcp_pkg::CH_NINE)
                     || (lc >= hmcp_pkg::CH_LC_A && lc <= hmcp_pkg::CH_LC_F))
            begin
                digit = (c <= hmcp_pkg::CH_NINE) ? c - hmcp_pkg::CH_ZERO
                                                 : lc - hmcp_pkg::CH_LC_A + 8'd10;
                settle_examine(c);
                acc         = {acc[27:0], digit[3:0]};
                digits_seen = 1'b1;
            end
            else if (c == hmcp_pkg::CH_SPACE)
            begin
                close_number();
            end
            else
            begin
                close_number();
                settle_examine(c);
                if (c == hmcp_pkg::CH_NUL)
                begin
                    add_word(hmcp_pkg::OP_DONE, '0, '0, '0);
                    clear_line();
                end
                else if (c == hmcp_pkg::CH_COLON)
                begin
                    mode = hmcp_pkg::MODE_STORE;
                end
                else if (c == hmcp_pkg::CH_DOT)
                begin
                    mode = hmcp_pkg::MODE_RANGE;
                end
                else if (c == hmcp_pkg::CH_UC_R || c == hmcp_pkg::CH_LC_R)
                begin
                    add_word((cur_addr < hmcp_pkg::RUN_LIMIT) ? hmcp_pkg::OP_RUN
                                                              : hmcp_pkg::OP_RUN_ERR,
                             cur_addr, '0, '0);
                    line_ignored = 1'b1;
                end
                else
                begin
                    add_word(hmcp_pkg::OP_SYNTAX, '0, '0, '0);
                    line_ignored = 1'b1;
                end
            end
            if (batch.size() > 0)
            begin
                batch[batch.size() - 1].last = 1'b1;
            end
            foreach (batch[i])
            begin
                due_words.push_back(batch[i]);
            end
        endfunction

        function void match_word(input hmcp_pkg::res_t got);
            hmcp_pkg::res_t want;
            if (due_words.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word op=%0d from=%h to=%h data=%h last=%b",
                         $time, got.op, got.addr_from, got.addr_to, got.data_byte, got.last);
                return;
            end
            want = due_words.pop_front();
            if (got !== want)
            begin
                errors++;
                $display("%0t: expected op=%0d from=%h to=%h data=%h last=%b", $time,
                         want.op, want.addr_from, want.addr_to, want.data_byte, want.last);
                $display("%0t:   actual op=%0d from=%h to=%h data=%h last=%b", $time,
                         got.op, got.addr_from, got.addr_to, got.data_byte, got.last);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   calm;
    int   cycles = 0;
    int   sent;

    command_tracker tracker;

    hmcp_char_if char_bus();
    hmcp_res_if  res_bus();

    hex_monitor_command_parser dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_in (char_bus),
        .res_out (res_bus)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("hex_monitor_command_parser verification failed");
            $finish;
        end
    end

    initial
    begin
        int             stall_left;
        hmcp_pkg::res_t got;
        stall_left = 0;
        res_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_bus.valid && res_bus.ready)
            begin
                got.op        = res_bus.op;
                got.addr_from = res_bus.addr_from;
                got.addr_to   = res_bus.addr_to;
                got.data_byte = res_bus.data_byte;
                got.last      = res_bus.last;
                tracker.match_word(got);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                res_bus.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 11);
                res_bus.ready <= 1'b0;
            end
            else
            begin
                res_bus.ready <= 1'b1;
            end
        end
    end

    task automatic send_char(input logic [7:0] c);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            char_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        char_bus.valid     <= 1'b1;
        char_bus.char_code <= c;
        do
            @(posedge clk);
        while (!char_bus.ready);
        tracker.take_char(c);
        sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_char(s[i]);
        end
    endtask

    task automatic send_number(input int ndigits);
        logic [3:0] nib;
        logic [7:0] c;
        repeat (ndigits)
        begin
            nib = 4'($urandom_range(0, 15));
            if (nib < 10)
            begin
                c = hmcp_pkg::CH_ZERO + nib;
            end
            else
            begin
                c = hmcp_pkg::CH_LC_A + nib - 8'd10;
                if ($urandom_range(0, 1))
                begin
                    c = c & ~hmcp_pkg::CASE_BIT;
                end
            end
            send_char(c);
        end
    endtask

    function automatic int digit_count();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
        begin
            return $urandom_range(1, 4);
        end
        if (pick < 9)
        begin
            return $urandom_range(5, 8);
        end
        return $urandom_range(9, 10);
    endfunction

    task automatic random_line();
        int shape;
        shape = $urandom_range(0, 9);
        if (shape < 4)
        begin
            send_number(digit_count());
            send_char(hmcp_pkg::CH_COLON);
            repeat ($urandom_range(1, 6))
            begin
                send_char(hmcp_pkg::CH_SPACE);
                send_number($urandom_range(1, 3));
            end
        end
        else if (shape < 6)
        begin
            send_number(digit_count());
            send_char(hmcp_pkg::CH_DOT);
            send_number(digit_count());
        end
        else if (shape < 8)
        begin
            repeat ($urandom_range(1, 4))
            begin
                send_number(digit_count());
                send_char(hmcp_pkg::CH_SPACE);
            end
        end
        else
        begin
            repeat ($urandom_range(1, 8))
            begin
                case ($urandom_range(0, 5))
                    0: send_char(8'($urandom_range(0, 255)));
                    1: send_char(hmcp_pkg::CH_SPACE);
                    2: send_char(hmcp_pkg::CH_COLON);
                    3: send_char(hmcp_pkg::CH_DOT);
                    4: send_number(digit_count());
                    default: send_char(8'(hmcp_pkg::CH_LC_F + $urandom_range(1, 11)));
                endcase
            end
        end
        if ($urandom_range(0, 5) == 0)
        begin
            send_char($urandom_range(0, 1) ? hmcp_pkg::CH_UC_R : hmcp_pkg::CH_LC_R);
            repeat ($urandom_range(0, 3)) send_char(8'($urandom_range(1, 255)));
        end
        if ($urandom_range(0, 19) != 0)
        begin
            send_char(hmcp_pkg::CH_NUL);
        end
    endtask

    initial
    begin
        tracker = new();
        calm    = 1'b0;
        sent    = 0;
        rst_n              <= 1'b0;
        char_bus.valid     <= 1'b0;
        char_bus.char_code <= hmcp_pkg::CH_NUL;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("FFFFfffff:1R");
        send_text("x");
        send_char(hmcp_pkg::CH_NUL);
        send_text("5.3");
        send_char(hmcp_pkg::CH_NUL);
        send_char(8'hFF);
        send_char(hmcp_pkg::CH_NUL);
        send_text("10000r");
        send_char(hmcp_pkg::CH_NUL);

        while (sent < ITEM_COUNT)
        begin
            calm = (sent >= ITEM_COUNT - CALM_ITEMS);
            random_line();
        end
        char_bus.valid <= 1'b0;

        while (tracker.due_words.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.errors == 0 && tracker.due_words.size() == 0)
        begin
            $display("hex_monitor_command_parser verification clean");
        end
        else
        begin
            $display("hex_monitor_command_parser verification failed");
        end
        $finish;
    end

endmodule
